### rtl/ptvc_pkg.sv
// ----------------------------------------------------------------------------
// ptvc_pkg
// Shared widths, codes and register indexes of the porosity tensor check.
// ----------------------------------------------------------------------------
package ptvc_pkg;

   // field and register widths
   localparam int IN_W       = 18;   // Q16 signed inputs
   localparam int MIN_EIG_W  = 17;
   localparam int RATIO_W    = 26;
   localparam int CSR_DATA_W = 26;
   localparam int CSR_IDX_W  = 1;
   localparam int CODE_W     = 3;

   // datapath widths of the ratio check
   localparam int C_W       = 27;   // 1.0 + ratio
   localparam int C2_W      = 53;   // (1.0 + ratio)^2
   localparam int DISC_W    = 38;   // (xx-yy)^2 + 4*xy^2
   localparam int D_W       = 44;   // trace * (ratio - 1.0)
   localparam int C2_LO_W   = 27;
   localparam int DISC_LO_W = 19;
   localparam int D_LO_W    = 22;
   localparam int LHS_W     = 91;
   localparam int RHS_W     = 88;

   localparam int ONE_Q16 = 65536;

   localparam logic [MIN_EIG_W-1:0] MIN_EIG_RESET = MIN_EIG_W'(66);
   localparam logic [RATIO_W-1:0]   RATIO_RESET   = RATIO_W'(6553600);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_EIG   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATIO = 1'b1;

   // first failed check
   typedef enum logic [CODE_W-1:0] {
      FC_OK        = 3'd0,
      FC_PORO_LOW  = 3'd1,
      FC_PORO_HIGH = 3'd2,
      FC_DIAG      = 3'd3,
      FC_DET       = 3'd4,
      FC_EIG_MIN   = 3'd5,
      FC_EIG_MAX   = 3'd6,
      FC_RATIO     = 3'd7
   } fail_code_type;

endpackage

### rtl/ptvc_ratio_mul.sv
// ----------------------------------------------------------------------------
// ptvc_ratio_mul
// Two-stage wide products for the condition ratio test:
// lhs = c2 * disc, rhs = d * d, built from partial products.
// ----------------------------------------------------------------------------
module ptvc_ratio_mul (
   input  logic                          clock,
   input  logic [ptvc_pkg::C2_W-1:0]     c2,
   input  logic [ptvc_pkg::DISC_W-1:0]   disc,
   input  logic [ptvc_pkg::D_W-1:0]      dval,
   output logic [ptvc_pkg::LHS_W-1:0]    lhs,
   output logic [ptvc_pkg::RHS_W-1:0]    rhs
);
   import ptvc_pkg::*;

   localparam int C2_HI_W   = C2_W - C2_LO_W;
   localparam int DISC_HI_W = DISC_W - DISC_LO_W;
   localparam int D_HI_W    = D_W - D_LO_W;

   logic [C2_LO_W+DISC_LO_W-1:0] p00_in, p00_ff;
   logic [C2_LO_W+DISC_HI_W-1:0] p01_in, p01_ff;
   logic [C2_HI_W+DISC_LO_W-1:0] p10_in, p10_ff;
   logic [C2_HI_W+DISC_HI_W-1:0] p11_in, p11_ff;
   logic [2*D_LO_W-1:0]          q00_in, q00_ff;
   logic [D_LO_W+D_HI_W-1:0]     q01_in, q01_ff;
   logic [2*D_HI_W-1:0]          q11_in, q11_ff;
   logic [LHS_W-1:0]             lhs_in, lhs_ff;
   logic [RHS_W-1:0]             rhs_in, rhs_ff;

   // stage A: partial products, each narrow enough for one multiplier
   always_comb begin
      p00_in = c2[C2_LO_W-1:0]    * disc[DISC_LO_W-1:0];
      p01_in = c2[C2_LO_W-1:0]    * disc[DISC_W-1:DISC_LO_W];
      p10_in = c2[C2_W-1:C2_LO_W] * disc[DISC_LO_W-1:0];
      p11_in = c2[C2_W-1:C2_LO_W] * disc[DISC_W-1:DISC_LO_W];
      q00_in = dval[D_LO_W-1:0]   * dval[D_LO_W-1:0];
      q01_in = dval[D_LO_W-1:0]   * dval[D_W-1:D_LO_W];
      q11_in = dval[D_W-1:D_LO_W] * dval[D_W-1:D_LO_W];
   end

   // stage B: shifted sums
   always_comb begin
      lhs_in = LHS_W'(p00_ff)
             + (LHS_W'(p01_ff) << DISC_LO_W)
             + (LHS_W'(p10_ff) << C2_LO_W)
             + (LHS_W'(p11_ff) << (C2_LO_W + DISC_LO_W));
      // cross term appears twice
      rhs_in = RHS_W'(q00_ff)
             + (RHS_W'(q01_ff) << (D_LO_W + 1))
             + (RHS_W'(q11_ff) << (2 * D_LO_W));
   end

   always_ff @(posedge clock) begin
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      p11_ff <= p11_in;
      q00_ff <= q00_in;
      q01_ff <= q01_in;
      q11_ff <= q11_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
   end

   assign lhs = lhs_ff;
   assign rhs = rhs_ff;

endmodule

### rtl/porosity_tensor_validity_check.sv
// ----------------------------------------------------------------------------
// porosity_tensor_validity_check
// Pipelined validity check of a cell porosity and its symmetric 2x2 tensor.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beat: drive req_* and raise start; the beat is taken at a clock
//    edge where start is high and busy is low. busy is high only while the
//    block comes out of reset, so one beat may be taken every cycle.
//  - Result beat: rsp_valid is high for exactly one cycle with
//    rsp_consistent and rsp_fail_code; the receiver cannot hold it off.
//  - Pipeline: six stages (three check stages, two stages of the wide ratio
//    products, one output register). Throughput is one beat per cycle while
//    busy is low; the pipeline never stalls since nothing is carried between
//    cells.
//  - Config: csr_we/csr_index/csr_wdata write min_eigenvalue (index 0) or
//    max_condition_ratio (index 1); write only with the pipeline empty.
//  - Reset (synchronous, active high) drops every beat in flight and loads
//    the register defaults (66 and 100.0 in Q16).
//  - Checks are exact: every compare against the root of the discriminant
//    is done on squares of integers; the ratio test needs 91-bit products,
//    which the ratio multiplier forms from 27x19 and 22x22 partials.
// ----------------------------------------------------------------------------
module porosity_tensor_validity_check (
   input  logic                                clock,
   input  logic                                reset,
   // input beat
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ptvc_pkg::IN_W-1:0]    req_total_porosity,
   input  logic signed [ptvc_pkg::IN_W-1:0]    req_tensor_xx,
   input  logic signed [ptvc_pkg::IN_W-1:0]    req_tensor_xy,
   input  logic signed [ptvc_pkg::IN_W-1:0]    req_tensor_yy,
   // result beat
   output logic                                rsp_valid,
   output logic                                rsp_consistent,
   output logic [ptvc_pkg::CODE_W-1:0]         rsp_fail_code,
   // configuration
   input  logic                                csr_we,
   input  logic [ptvc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptvc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ptvc_pkg::*;

   // ---------------------------------------------------------------- config
   logic [MIN_EIG_W-1:0] min_eig_ff;
   logic [RATIO_W-1:0]   ratio_ff;
   logic                 busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_eig_ff <= MIN_EIG_RESET;
         ratio_ff   <= RATIO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_EIG:   min_eig_ff <= csr_wdata[MIN_EIG_W-1:0];
            CSR_MAX_RATIO: ratio_ff   <= csr_wdata[RATIO_W-1:0];
            default:       ;
         endcase
      end
   end

   // busy is the registered reset: high through reset and in the cycle that follows it
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   logic accept;
   assign accept = start && !busy_ff;

   // ---------------------------------------------------------------- stage 1
   // scalar checks, diagonal sign, products for the determinant, trace terms
   logic signed [IN_W-1:0]   dmax;
   logic signed [IN_W:0]     tr_full;
   logic                     f1, f2, f3;
   fail_code_type            s1_code_in, s1_code_ff;
   logic signed [2*IN_W-1:0] s1_pxy_in, s1_pxy_ff;
   logic signed [2*IN_W-1:0] s1_qxy_in, s1_qxy_ff;
   logic signed [IN_W:0]     s1_df_in, s1_df_ff;
   logic signed [IN_W+1:0]   s1_a_in, s1_a_ff;     // trace - 2*min_eig
   logic signed [IN_W+1:0]   s1_b_in, s1_b_ff;     // 2.0 - trace
   logic [C_W-1:0]           s1_c_in, s1_c_ff;     // 1.0 + ratio
   logic [IN_W-1:0]          s1_tr_ff;
   logic [RATIO_W-1:0]       s1_rm_in, s1_rm_ff;   // ratio - 1.0
   logic                     s1_rneg_in, s1_rneg_ff;
   logic                     s1_valid_ff;

   always_comb begin
      dmax = (req_tensor_xx > req_tensor_yy) ? req_tensor_xx : req_tensor_yy;
      f1 = req_total_porosity < dmax;
      f2 = req_total_porosity > IN_W'(ONE_Q16);
      f3 = (req_tensor_xx <= IN_W'(0)) || (req_tensor_yy <= IN_W'(0));
      if (f1) begin
         s1_code_in = FC_PORO_LOW;
      end else if (f2) begin
         s1_code_in = FC_PORO_HIGH;
      end else if (f3) begin
         s1_code_in = FC_DIAG;
      end else begin
         s1_code_in = FC_OK;
      end
      s1_pxy_in  = req_tensor_xx * req_tensor_yy;
      s1_qxy_in  = req_tensor_xy * req_tensor_xy;
      tr_full    = {req_tensor_xx[IN_W-1], req_tensor_xx}
                 + {req_tensor_yy[IN_W-1], req_tensor_yy};
      s1_df_in   = {req_tensor_xx[IN_W-1], req_tensor_xx}
                 - {req_tensor_yy[IN_W-1], req_tensor_yy};
      s1_a_in    = {tr_full[IN_W], tr_full} - $signed({2'b00, min_eig_ff, 1'b0});
      s1_b_in    = (IN_W+2)'(2 * ONE_Q16) - {tr_full[IN_W], tr_full};
      s1_c_in    = {1'b0, ratio_ff} + C_W'(ONE_Q16);
      s1_rm_in   = ratio_ff - RATIO_W'(ONE_Q16);
      s1_rneg_in = ratio_ff < RATIO_W'(ONE_Q16);
   end

   // ---------------------------------------------------------------- stage 2
   // determinant check; squares for the eigenvalue and ratio tests
   logic signed [2*IN_W:0]   det;
   logic signed [2*IN_W+1:0] dfsq_full;
   fail_code_type            s2_code_in, s2_code_ff;
   logic [2*IN_W:0]          s2_dfsq_ff;
   logic [2*IN_W-2:0]        s2_qxy_ff;
   logic [2*IN_W-1:0]        s2_asq_in, s2_asq_ff;
   logic [2*IN_W-1:0]        s2_bsq_in, s2_bsq_ff;
   logic                     s2_aneg_ff, s2_bneg_ff;
   logic [2*C_W-1:0]         c2_full;
   logic [C2_W-1:0]          s2_c2_ff;
   logic [D_W-1:0]           s2_d_in, s2_d_ff;
   logic                     s2_rneg_ff;
   logic                     s2_valid_ff;

   always_comb begin
      det = {s1_pxy_ff[2*IN_W-1], s1_pxy_ff} - {s1_qxy_ff[2*IN_W-1], s1_qxy_ff};
      if (s1_code_ff != FC_OK) begin
         s2_code_in = s1_code_ff;
      end else if (det <= (2*IN_W+1)'(0)) begin
         s2_code_in = FC_DET;
      end else begin
         s2_code_in = FC_OK;
      end
      dfsq_full = s1_df_ff * s1_df_ff;
      s2_asq_in = s1_a_ff[IN_W-1:0] * s1_a_ff[IN_W-1:0];
      s2_bsq_in = s1_b_ff[IN_W-1:0] * s1_b_ff[IN_W-1:0];
      c2_full   = s1_c_ff * s1_c_ff;
      s2_d_in   = s1_tr_ff * s1_rm_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // discriminant, eigenvalue bounds
   logic [DISC_W-1:0] s3_disc_in, s3_disc_ff;
   logic              f5, f6;
   fail_code_type     s3_code_in, s3_code_ff;
   logic [C2_W-1:0]   s3_c2_ff;
   logic [D_W-1:0]    s3_d_ff;
   logic              s3_rneg_ff;
   logic              s3_valid_ff;

   always_comb begin
      s3_disc_in = DISC_W'(s2_dfsq_ff) + DISC_W'({s2_qxy_ff, 2'b00});
      f5 = s2_aneg_ff || (DISC_W'(s2_asq_ff) < s3_disc_in);
      f6 = s2_bneg_ff || (s3_disc_in > DISC_W'(s2_bsq_ff));
      if (s2_code_ff != FC_OK) begin
         s3_code_in = s2_code_ff;
      end else if (f5) begin
         s3_code_in = FC_EIG_MIN;
      end else if (f6) begin
         s3_code_in = FC_EIG_MAX;
      end else begin
         s3_code_in = FC_OK;
      end
   end

   // ------------------------------------------------------- stages 4 and 5
   // ratio products; code and valid ride alongside
   logic [LHS_W-1:0] lhs;
   logic [RHS_W-1:0] rhs;
   fail_code_type    s4_code_ff, s5_code_ff;
   logic             s4_rneg_ff, s5_rneg_ff;
   logic             s4_valid_ff, s5_valid_ff;

   ptvc_ratio_mul u_ratio_mul (
      .clock (clock),
      .c2    (s3_c2_ff),
      .disc  (s3_disc_ff),
      .dval  (s3_d_ff),
      .lhs   (lhs),
      .rhs   (rhs)
   );

   // ---------------------------------------------------------------- output
   logic          f7;
   fail_code_type out_code_in, out_code_ff;
   logic          rsp_valid_ff;

   always_comb begin
      // ratio below 1.0 makes the right side negative: always too large
      f7 = s5_rneg_ff || (lhs > LHS_W'(rhs));
      if (s5_code_ff != FC_OK) begin
         out_code_in = s5_code_ff;
      end else if (f7) begin
         out_code_in = FC_RATIO;
      end else begin
         out_code_in = FC_OK;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_code_ff  <= s1_code_in;
      s1_pxy_ff   <= s1_pxy_in;
      s1_qxy_ff   <= s1_qxy_in;
      s1_df_ff    <= s1_df_in;
      s1_a_ff     <= s1_a_in;
      s1_b_ff     <= s1_b_in;
      s1_c_ff     <= s1_c_in;
      s1_tr_ff    <= tr_full[IN_W-1:0];
      s1_rm_ff    <= s1_rm_in;
      s1_rneg_ff  <= s1_rneg_in;

      s2_code_ff  <= s2_code_in;
      s2_dfsq_ff  <= dfsq_full[2*IN_W:0];
      s2_qxy_ff   <= s1_qxy_ff[2*IN_W-2:0];
      s2_asq_ff   <= s2_asq_in;
      s2_bsq_ff   <= s2_bsq_in;
      s2_aneg_ff  <= s1_a_ff[IN_W+1];
      s2_bneg_ff  <= s1_b_ff[IN_W+1];
      s2_c2_ff    <= c2_full[C2_W-1:0];
      s2_d_ff     <= s2_d_in;
      s2_rneg_ff  <= s1_rneg_ff;

      s3_code_ff  <= s3_code_in;
      s3_disc_ff  <= s3_disc_in;
      s3_c2_ff    <= s2_c2_ff;
      s3_d_ff     <= s2_d_ff;
      s3_rneg_ff  <= s2_rneg_ff;

      s4_code_ff  <= s3_code_ff;
      s4_rneg_ff  <= s3_rneg_ff;
      s5_code_ff  <= s4_code_ff;
      s5_rneg_ff  <= s4_rneg_ff;

      out_code_ff <= out_code_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fail_code  = out_code_ff;
   assign rsp_consistent = (out_code_ff == FC_OK);

`ifndef SYNTHESIS
   // every accepted beat comes out as a result beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("accepted beat did not produce a result");

   // no result without an earlier accepted beat
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result without an accepted beat");

   // a pass needs positive diagonals and porosity within one
   a_pass_inputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_consistent |->
         $past((req_tensor_xx > IN_W'(0)) && (req_tensor_yy > IN_W'(0))
               && (req_total_porosity <= IN_W'(ONE_Q16)), 6))
      else $error("pass reported for out-of-range inputs");

   // scalar below the xx diagonal is always the reported code
   a_poro_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(accept && (req_total_porosity < req_tensor_xx), 6)
         |-> rsp_fail_code == FC_PORO_LOW)
      else $error("porosity below diagonal not reported first");
`endif

endmodule

### tb/sv/ptvc_verdict_checker.sv
// ----------------------------------------------------------------------------
// ptvc_verdict_checker
// Watches the input, result and register ports of the porosity tensor check,
// works out the verdict of every accepted cell and compares it in order with
// the result beats.
// ----------------------------------------------------------------------------
module ptvc_verdict_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [ptvc_pkg::IN_W-1:0]     req_total_porosity,
   input  logic signed [ptvc_pkg::IN_W-1:0]     req_tensor_xx,
   input  logic signed [ptvc_pkg::IN_W-1:0]     req_tensor_xy,
   input  logic signed [ptvc_pkg::IN_W-1:0]     req_tensor_yy,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_consistent,
   input  logic [ptvc_pkg::CODE_W-1:0]          rsp_fail_code,
   input  logic                                 csr_we,
   input  logic [ptvc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptvc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   mismatches,
   output int                                   in_flight,
   output int                                   cells_checked,
   output logic [7:0]                           codes_seen
);
   import ptvc_pkg::*;

   typedef struct packed {
      logic          consistent;
      fail_code_type code;
   } cell_verdict_type;

   cell_verdict_type     pending_verdicts[$];
   logic [MIN_EIG_W-1:0] min_eig_q = MIN_EIG_RESET;
   logic [RATIO_W-1:0]   ratio_q   = RATIO_RESET;
   int                   error_total = 0;
   int                   checked_total = 0;
   logic [7:0]           code_mask = '0;

   // First failed check of one cell; exact integer form of every root compare.
   function automatic fail_code_type first_failed_check(
      input logic signed [IN_W-1:0] poro, txx, txy, tyy,
      input logic [MIN_EIG_W-1:0]   min_eig,
      input logic [RATIO_W-1:0]     ratio);
      longint          p, xx, xy, yy, dmax, det, tr, df, a, b, d;
      longint unsigned disc, c, csq;
      logic [127:0]    lhs, rhs;
      p  = poro;
      xx = txx;
      xy = txy;
      yy = tyy;
      dmax = (xx > yy) ? xx : yy;
      if (p < dmax) return FC_PORO_LOW;
      if (p > ONE_Q16) return FC_PORO_HIGH;
      if (xx <= 0 || yy <= 0) return FC_DIAG;
      det = xx * yy - xy * xy;
      if (det <= 0) return FC_DET;
      tr   = xx + yy;
      df   = xx - yy;
      disc = df * df + 4 * xy * xy;
      // smaller eigenvalue < m  <=>  tr - 2m < sqrt(disc)
      a = tr - 2 * longint'(min_eig);
      if (a < 0 || longint'(a * a) < 0 || (a * a) < disc) return FC_EIG_MIN;
      // larger eigenvalue > 1  <=>  sqrt(disc) > 2 - tr
      b = 2 * longint'(ONE_Q16) - tr;
      if (b < 0 || disc > (b * b)) return FC_EIG_MAX;
      // (tr+s)*1.0 > R*(tr-s)  <=>  s*(1.0+R) > tr*(R-1.0), squared
      d = tr * (longint'(ratio) - ONE_Q16);
      if (d < 0) return FC_RATIO;
      c   = ONE_Q16 + longint'(ratio);
      csq = c * c;
      lhs = 128'(csq) * 128'(disc);
      rhs = 128'(d) * 128'(d);
      if (lhs > rhs) return FC_RATIO;
      return FC_OK;
   endfunction

   always @(posedge clock) begin
      cell_verdict_type want;
      if (reset) begin
         min_eig_q = MIN_EIG_RESET;
         ratio_q   = RATIO_RESET;
         pending_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_EIG:   min_eig_q = csr_wdata[MIN_EIG_W-1:0];
               CSR_MAX_RATIO: ratio_q   = csr_wdata[RATIO_W-1:0];
               default:       ;
            endcase
         end
         if (start && !busy) begin
            want.code = first_failed_check(req_total_porosity, req_tensor_xx,
                                           req_tensor_xy, req_tensor_yy,
                                           min_eig_q, ratio_q);
            want.consistent = (want.code == FC_OK);
            pending_verdicts.push_back(want);
         end
         if (rsp_valid) begin
            if (pending_verdicts.size() == 0) begin
               error_total++;
               $display("%0t: result beat with nothing expected: expected none, got %0d/%0d",
                        $time, rsp_consistent, rsp_fail_code);
            end else begin
               want = pending_verdicts.pop_front();
               checked_total++;
               code_mask[want.code] = 1'b1;
               if (rsp_consistent !== want.consistent) begin
                  error_total++;
                  $display("%0t: consistent mismatch: expected %0d, got %0d",
                           $time, want.consistent, rsp_consistent);
               end
               if (rsp_fail_code !== want.code) begin
                  error_total++;
                  $display("%0t: fail_code mismatch: expected %0d, got %0d",
                           $time, want.code, rsp_fail_code);
               end
            end
         end
      end
      mismatches    <= error_total;
      in_flight     <= pending_verdicts.size();
      cells_checked <= checked_total;
      codes_seen    <= code_mask;
   end

endmodule

### tb/sv/porosity_tensor_validity_check_tb.sv
// ----------------------------------------------------------------------------
// porosity_tensor_validity_check_tb
// Drives directed and random cells through the porosity tensor check under
// several register settings, with bursty input pacing; a side checker
// predicts each verdict and compares it with the result beats.
// ----------------------------------------------------------------------------
module porosity_tensor_validity_check_tb;
   import ptvc_pkg::*;

   localparam int ONE        = ONE_Q16;
   localparam int RATIO_TOP  = (1 << RATIO_W) - 1;
   localparam int DRAIN_WAIT = 200;   // bound on the final drain, in cycles
   localparam int SETTLE     = 12;    // pipeline is six stages deep

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [IN_W-1:0]  req_total_porosity = '0;
   logic signed [IN_W-1:0]  req_tensor_xx = '0;
   logic signed [IN_W-1:0]  req_tensor_xy = '0;
   logic signed [IN_W-1:0]  req_tensor_yy = '0;
   logic                    rsp_valid;
   logic                    rsp_consistent;
   logic [CODE_W-1:0]       rsp_fail_code;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_MIN_EIG;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int                      mismatches;
   int                      in_flight;
   int                      cells_checked;
   logic [7:0]              codes_seen;

   int                      burst_left = 0;
   int                      settings_run = 1;   // reset defaults count as one

   always #4 clock = ~clock;

   porosity_tensor_validity_check dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_total_porosity (req_total_porosity),
      .req_tensor_xx      (req_tensor_xx),
      .req_tensor_xy      (req_tensor_xy),
      .req_tensor_yy      (req_tensor_yy),
      .rsp_valid          (rsp_valid),
      .rsp_consistent     (rsp_consistent),
      .rsp_fail_code      (rsp_fail_code),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   ptvc_verdict_checker verdict_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_total_porosity (req_total_porosity),
      .req_tensor_xx      (req_tensor_xx),
      .req_tensor_xy      (req_tensor_xy),
      .req_tensor_yy      (req_tensor_yy),
      .rsp_valid          (rsp_valid),
      .rsp_consistent     (rsp_consistent),
      .rsp_fail_code      (rsp_fail_code),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .in_flight          (in_flight),
      .cells_checked      (cells_checked),
      .codes_seen         (codes_seen)
   );

   // One input beat. Called at a rising edge; returns at the edge that took it.
   // busy only moves on rising edges, so its value at the falling edge is the
   // one the next rising edge sees.
   task automatic drive_cell(input int poro, txx, txy, tyy);
      req_total_porosity <= IN_W'(poro);
      req_tensor_xx      <= IN_W'(txx);
      req_tensor_xy      <= IN_W'(txy);
      req_tensor_yy      <= IN_W'(tyy);
      start              <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // Bursts of random length with random gaps; now and then a long burst
   // with no gap at all, so back-to-back beats fill the whole pipeline.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Hold off until every expected result beat has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (in_flight != 0);
      @(posedge clock);
   endtask

   // Both registers in consecutive cycles; write enable stays high throughout.
   task automatic write_both(input logic [CSR_DATA_W-1:0] min_eig, ratio);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_EIG;
      csr_wdata <= min_eig;
      @(posedge clock);
      csr_index <= CSR_MAX_RATIO;
      csr_wdata <= ratio;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_run++;
   endtask

   // Mostly well-formed tensors (positive diagonal, bounded off-diagonal,
   // porosity near the diagonal max) so the eigen and ratio checks are
   // reached; the rest is raw noise over all 18 bits of every field.
   task automatic make_cell(output logic signed [IN_W-1:0] poro, txx, txy, tyy);
      int dxx, dyy, dxy, lim, dmax, p;
      if ($urandom_range(0, 9) < 2) begin
         poro = IN_W'($urandom);
         txx  = IN_W'($urandom);
         txy  = IN_W'($urandom);
         tyy  = IN_W'($urandom);
      end else begin
         dxx = 1 + ($urandom_range(0, 65535) >> $urandom_range(0, 16));
         if ($urandom_range(0, 5) == 0)
            dxx = ONE - int'($urandom_range(0, 300));   // eigenvalue near 1.0
         dyy = ($urandom_range(0, 4) == 0) ? dxx
                : 1 + ($urandom_range(0, 65535) >> $urandom_range(0, 16));
         lim = (dxx < dyy) ? dxx : dyy;
         dxy = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, lim));
         if ($urandom_range(0, 7) == 0)
            dxy = lim + int'($urandom_range(0, 64));   // off-diagonal at or above the smaller diagonal
         if ($urandom_range(0, 1) == 1)
            dxy = -dxy;
         if ($urandom_range(0, 9) == 0)
            dxx = 0 - int'($urandom_range(0, 100));    // nonpositive diagonal
         if ($urandom_range(0, 1) == 1) begin
            lim = dxx;
            dxx = dyy;
            dyy = lim;
         end
         dmax = (dxx > dyy) ? dxx : dyy;
         case ($urandom_range(0, 5))
            0:       p = dmax;
            1:       p = dmax - int'($urandom_range(1, 64));
            2:       p = ONE + int'($urandom_range(1, 64));
            default: p = (dmax < ONE) ? int'($urandom_range(dmax, ONE)) : dmax;
         endcase
         poro = IN_W'(p);
         txx  = IN_W'(dxx);
         txy  = IN_W'(dxy);
         tyy  = IN_W'(dyy);
      end
   endtask

   // One register setting's worth of random beats, with one full drain
   // somewhere in the middle.
   task automatic run_random(input int count);
      logic signed [IN_W-1:0] poro, txx, txy, tyy;
      int pause_at;
      pause_at = $urandom_range(count / 4, (3 * count) / 4);
      for (int k = 0; k < count; k++) begin
         pace_sender();
         if (k == pause_at)
            wait_drained();
         make_cell(poro, txx, txy, tyy);
         drive_cell(int'(poro), int'(txx), int'(txy), int'(tyy));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed cells under the reset registers (min 66, ratio 100.0).
      drive_cell(0, 0, 0, 0);                           // zero diagonal
      drive_cell(-131072, 0, 0, 0);                     // porosity below max diagonal
      drive_cell(131071, -131072, 131071, -131072);     // porosity above one
      drive_cell(131071, 131071, -131072, 131071);      // field extremes, above one
      drive_cell(30000, 40000, 0, 20000);               // porosity below xx
      drive_cell(ONE + 1, 100, 0, 100);                 // just above one
      drive_cell(ONE, 100, 0, -5);                      // negative yy
      drive_cell(ONE, 0, 0, 100);                       // zero xx
      drive_cell(ONE, ONE / 2, 0, ONE / 2);             // clean pass
      drive_cell(ONE, ONE / 2, ONE / 2, ONE / 2);       // determinant exactly zero
      drive_cell(ONE, ONE, -131072, ONE);               // determinant negative
      drive_cell(ONE, 1, 0, 1);                         // tiny eigenvalues
      drive_cell(ONE, 65, 0, 66);                       // min eigenvalue one below limit
      drive_cell(ONE, 66, 0, 66);                       // min eigenvalue on the limit
      drive_cell(ONE, ONE, 1, ONE);                     // max eigenvalue just over one
      drive_cell(ONE, ONE, 0, ONE);                     // max eigenvalue exactly one
      drive_cell(ONE, ONE, 0, 100);                     // condition ratio far too large
      drive_cell(ONE, ONE, 0, 656);                     // ratio just under 100
      drive_cell(ONE, 10000, 0, 100);                   // ratio exactly 100
      drive_cell(ONE, 10001, 0, 100);                   // ratio just over 100
      drive_cell(ONE, 40000, -20000, 30000);            // off-diagonal, negative sign

      run_random(200);

      // Lowest in-range registers: ratio 1.0 fails any split eigenvalues.
      wait_drained();
      write_both(CSR_DATA_W'(1), CSR_DATA_W'(ONE));
      run_random(120);

      // Highest in-range min eigenvalue and widest ratio register.
      wait_drained();
      write_both(CSR_DATA_W'(ONE), CSR_DATA_W'(RATIO_TOP));
      run_random(100);

      // Min eigenvalue zero, carried by bits above its width that must be
      // dropped; ratio 0.5, below one, so every cell that gets that far fails.
      wait_drained();
      write_both(CSR_DATA_W'(26'h3FE0000), CSR_DATA_W'(ONE / 2));
      run_random(100);

      // A few random settings inside the useful range.
      repeat (3) begin
         wait_drained();
         write_both(CSR_DATA_W'($urandom_range(1, 4000)),
                    CSR_DATA_W'($urandom_range(ONE, 400 * ONE)));
         run_random(95);
      end

      // Drain, then let the pipeline run empty to catch any stray beat.
      start <= 1'b0;
      for (int w = 0; w < DRAIN_WAIT && in_flight != 0; w++)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      if (in_flight != 0)
         $display("%0t: %0d result beats never arrived", $time, in_flight);
      $display("Checked %0d cell verdicts over %0d register settings.",
               cells_checked, settings_run);
      $display("Fail codes seen (bit n = code n): %b", codes_seen);
      if (mismatches == 0 && in_flight == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
